FILE: hdl/ais_pkg.sv
// Shared types and constants for the ascending integer sorter.
package ais_pkg;

    localparam int DATA_W           = 32;
    localparam int DEF_MAX_ELEMENTS = 64;

    // One input request: an element and the end-of-set flag
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last_element;
    } t_in_req;

    // One output request: the next element in ascending order
    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_result;
        logic                     overflow;
    } t_out_req;

    // Controls broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctrl;

    // Sequencer states
    typedef enum logic [1:0] {
        S_LOAD = 2'b01,
        S_EMIT = 2'b10
    } t_state;

endpackage

FILE: hdl/ais_cell.sv
// One cell of the sorting chain: holds one element and trades with its neighbors.
module ais_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ais_pkg::t_cell_ctrl                i_ctrl,
    input  logic signed [ais_pkg::DATA_W-1:0]  i_new_value,
    input  logic signed [ais_pkg::DATA_W-1:0]  i_prev_value,
    input  logic                               i_prev_valid,
    input  logic                               i_prev_lt,
    input  logic signed [ais_pkg::DATA_W-1:0]  i_next_value,
    input  logic                               i_next_valid,
    output logic signed [ais_pkg::DATA_W-1:0]  o_value,
    output logic                               o_valid,
    output logic                               o_lt
);
    import ais_pkg::*;

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;
    logic                     r_valid;
    logic                     n_valid;

    // An empty cell acts as plus infinity
    assign o_lt    = !r_valid || (i_new_value < r_value);
    assign o_value = r_value;
    assign o_valid = r_valid;

    // Insert: move up from the left neighbor or take the new element; shift: pull from right
    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctrl.insert) begin
            if (o_lt) begin
                n_value = i_prev_lt ? i_prev_value : i_new_value;
            end
            n_valid = r_valid | i_prev_valid;
        end else if (i_ctrl.shift) begin
            n_value = i_next_value;
            n_valid = i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

FILE: hdl/ascending_integer_sorter.sv
// Top level of the ascending integer sorter: cell chain and load/emit sequencer.
//
// Usage: send a set of signed 32-bit elements on the input channel (i_valid,
// i_req, o_stall), one request per cycle, with last_element set on the final one.
// Up to MAX_ELEMENTS elements are kept in a row of cells ordered at all times;
// each new element is inserted as soon as it is accepted, so loading runs at one request per
// cycle. Further elements are dropped and overflow is then set on every result.
// In the cycle after the final request, the smallest element appears on the output
// channel (o_valid, o_res, i_stall); the chain shifts by one cell per result
// taken, giving one result per cycle while i_stall is low, last_result on the
// largest element. While results are being emitted o_stall is high and no
// input is taken; the next set is accepted in the cycle after the final result is
// taken. When the receiver stalls, the chain and the shown result hold unchanged.
// Reset (i_rst_n low, synchronous) empties the chain and clears the overflow flag.
module ascending_integer_sorter #(
    parameter int MAX_ELEMENTS = ais_pkg::DEF_MAX_ELEMENTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ais_pkg::t_in_req  i_req,
    output logic              o_stall,
    output logic              o_valid,
    output ais_pkg::t_out_req o_res,
    input  logic              i_stall
);
    import ais_pkg::*;

    t_state     r_state;
    t_state     n_state;
    logic       r_dropped;
    logic       n_dropped;
    t_cell_ctrl w_ctrl;
    logic       w_accept;
    logic       w_full;

    logic signed [DATA_W-1:0] w_value [MAX_ELEMENTS];
    logic                     w_valid [MAX_ELEMENTS];
    logic                     w_lt    [MAX_ELEMENTS];

    assign w_full   = w_valid[MAX_ELEMENTS-1];
    assign w_accept = (r_state == S_LOAD) && i_valid;
    assign o_stall  = (r_state != S_LOAD);

    // Broadcast insert while loading, shift when a result is taken
    assign w_ctrl.insert = w_accept && !w_full;
    assign w_ctrl.shift  = (r_state == S_EMIT) && !i_stall;

    // Build the chain: left edge never yields, right edge feeds an empty cell
    for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_pv;
        logic                     w_pvld;
        logic                     w_plt;
        logic signed [DATA_W-1:0] w_nv;
        logic                     w_nvld;

        if (g == 0) begin : g_head
            assign w_pv   = i_req.value;
            assign w_pvld = 1'b1;
            assign w_plt  = 1'b0;
        end else begin : g_body
            assign w_pv   = w_value[g-1];
            assign w_pvld = w_valid[g-1];
            assign w_plt  = w_lt[g-1];
        end

        if (g == MAX_ELEMENTS - 1) begin : g_tail
            assign w_nv   = w_value[g];
            assign w_nvld = 1'b0;
        end else begin : g_inner
            assign w_nv   = w_value[g+1];
            assign w_nvld = w_valid[g+1];
        end

        ais_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_new_value  (i_req.value),
            .i_prev_value (w_pv),
            .i_prev_valid (w_pvld),
            .i_prev_lt    (w_plt),
            .i_next_value (w_nv),
            .i_next_valid (w_nvld),
            .o_value      (w_value[g]),
            .o_valid      (w_valid[g]),
            .o_lt         (w_lt[g])
        );
    end

    // Sequence loading and emission; track dropped elements
    always_comb begin
        n_state   = r_state;
        n_dropped = r_dropped;
        unique case (r_state)
            S_LOAD: begin
                if (w_accept) begin
                    if (w_full) begin
                        n_dropped = 1'b1;
                    end
                    if (i_req.last_element) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (w_ctrl.shift && !w_valid[1]) begin
                    n_state   = S_LOAD;
                    n_dropped = 1'b0;
                end
            end
            default: begin
                n_state   = S_LOAD;
                n_dropped = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_dropped <= n_dropped;
        end
    end

    // Present the head cell as the current result
    assign o_valid            = (r_state == S_EMIT);
    assign o_res.sorted_value = w_value[0];
    assign o_res.last_result  = !w_valid[1];
    assign o_res.overflow     = r_dropped;

endmodule

FILE: tb/tb_ascending_integer_sorter.sv
// Self-checking testbench for the ascending integer sorter: directed sets, random sets, stalls.
module tb_ascending_integer_sorter;

    import ais_pkg::*;

    localparam int CAP          = DEF_MAX_ELEMENTS;
    localparam int RANDOM_ITEMS = 440;
    localparam int DRAIN_CYCLES = 2 * CAP + 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 10;

    localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

    // One row of the directed stimulus, with an optional typed-in result
    typedef struct packed {
        t_in_req  req;
        logic     typed;
        t_out_req want;
    } t_row;

    logic     clk      = 1'b0;
    logic     rst_n    = 1'b0;
    logic     tx_valid = 1'b0;
    t_in_req  tx_req   = '0;
    logic     rx_stall = 1'b0;
    logic     dut_busy;
    logic     res_valid;
    t_out_req res;

    // Sorter state as predicted from accepted requests
    logic signed [DATA_W-1:0] held_values [CAP];
    int       held_count   = 0;
    logic     held_dropped = 1'b0;
    t_out_req set_output [$];
    t_out_req sorted_due [$];

    int fail_count  = 0;
    int tx_idle_pct = 27;
    int rx_idle_pct = 72;
    int hold_asked  = 0;
    int hold_done   = 0;
    int hold_left   = 0;

    t_row directed_rows [$];

    ascending_integer_sorter #(
        .MAX_ELEMENTS(CAP)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (tx_valid),
        .i_req   (tx_req),
        .o_stall (dut_busy),
        .o_valid (res_valid),
        .o_res   (res),
        .i_stall (rx_stall)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // End the run if it hangs
    initial begin
        #400000;
        $display("FAIL ascending_integer_sorter");
        $finish;
    end

    // Store one element, and on the final one produce the set in ascending order
    function automatic void take_element(input t_in_req r);
        logic signed [DATA_W-1:0] ordered [CAP];
        logic signed [DATA_W-1:0] key;
        t_out_req                 item;
        int                       i;
        int                       j;
        set_output.delete();
        if (held_count < CAP) begin
            held_values[held_count] = r.value;
            held_count++;
        end else begin
            held_dropped = 1'b1;
        end
        if (!r.last_element) return;
        // insertion sort, signed compare
        for (i = 0; i < held_count; i++) begin
            key = held_values[i];
            j   = i;
            while (j > 0 && ordered[j-1] > key) begin
                ordered[j] = ordered[j-1];
                j--;
            end
            ordered[j] = key;
        end
        for (i = 0; i < held_count; i++) begin
            item.sorted_value = ordered[i];
            item.last_result  = (i == held_count - 1);
            item.overflow     = held_dropped;
            set_output.push_back(item);
        end
        held_count   = 0;
        held_dropped = 1'b0;
    endfunction

    function automatic t_row make_row(input logic signed [DATA_W-1:0] v, input logic last,
                                      input logic typed, input logic signed [DATA_W-1:0] wv);
        t_row r;
        r.req.value             = v;
        r.req.last_element      = last;
        r.typed                 = typed;
        r.want.sorted_value     = wv;
        r.want.last_result      = 1'b1;
        r.want.overflow         = 1'b0;
        return r;
    endfunction

    // Offer one request after a random gap, wait for it to be taken, then predict
    task automatic send_request(input t_in_req r, input logic typed, input t_out_req want);
        while ($urandom_range(99) < tx_idle_pct) begin
            tx_valid <= 1'b0;
            @(posedge clk);
        end
        tx_valid <= 1'b1;
        tx_req   <= r;
        @(posedge clk);
        while (dut_busy) @(posedge clk);
        take_element(r);
        if (typed && r.last_element) begin
            sorted_due.push_back(want);
        end else begin
            foreach (set_output[k]) sorted_due.push_back(set_output[k]);
        end
    endtask

    // Receiver: check each taken result, then pick the next stall
    always @(posedge clk) begin : rx_side
        t_out_req want;
        if (rst_n) begin
            if (res_valid && !rx_stall) begin
                if (sorted_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result: value %0d last %0b overflow %0b",
                                 res.sorted_value, res.last_result, res.overflow);
                end else begin
                    want = sorted_due.pop_front();
                    if (res.sorted_value !== want.sorted_value ||
                        res.last_result !== want.last_result ||
                        res.overflow !== want.overflow) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                                     want.sorted_value, want.last_result, want.overflow,
                                     res.sorted_value, res.last_result, res.overflow);
                    end
                end
            end
            // start a long hold when asked
            if (hold_left == 0 && hold_asked != hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = hold_asked;
            end
            if (hold_left > 0) begin
                hold_left--;
                rx_stall <= 1'b1;
            end else begin
                rx_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    // Stimulus and end of run
    initial begin : tx_side
        t_in_req                  r;
        t_out_req                 no_want;
        logic signed [DATA_W-1:0] v;
        int                       sent;
        int                       set_len;
        int                       k;
        int                       pick;
        logic                     pressed;
        no_want = '0;
        pressed = 1'b0;
        sent    = 0;

        // Directed sets: single extremes typed in, the rest predicted
        directed_rows.push_back(make_row(INT_MIN, 1'b1, 1'b1, INT_MIN));
        directed_rows.push_back(make_row(INT_MAX, 1'b1, 1'b1, INT_MAX));
        directed_rows.push_back(make_row(0, 1'b1, 1'b1, 0));
        directed_rows.push_back(make_row(-1, 1'b1, 1'b1, -1));
        directed_rows.push_back(make_row(INT_MAX, 1'b0, 1'b0, 0));
        directed_rows.push_back(make_row(INT_MIN, 1'b0, 1'b0, 0));
        directed_rows.push_back(make_row(7, 1'b0, 1'b0, 0));
        directed_rows.push_back(make_row(-7, 1'b0, 1'b0, 0));
        directed_rows.push_back(make_row(7, 1'b0, 1'b0, 0));
        directed_rows.push_back(make_row(0, 1'b1, 1'b0, 0));
        directed_rows.push_back(make_row(32'sh5555_5555, 1'b0, 1'b0, 0));
        directed_rows.push_back(make_row(32'shAAAA_AAAA, 1'b1, 1'b0, 0));
        directed_rows.push_back(make_row(42, 1'b0, 1'b0, 0));
        directed_rows.push_back(make_row(42, 1'b0, 1'b0, 0));
        directed_rows.push_back(make_row(42, 1'b1, 1'b0, 0));
        directed_rows.push_back(make_row(3, 1'b0, 1'b0, 0));
        directed_rows.push_back(make_row(2, 1'b0, 1'b0, 0));
        directed_rows.push_back(make_row(1, 1'b1, 1'b0, 0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

        // Random sets, mostly short, some at and beyond capacity
        while (sent < RANDOM_ITEMS) begin
            if (sent >= 300) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (sent >= 150) begin
                tx_idle_pct = 72;
                rx_idle_pct = 27;
            end
            pick = $urandom_range(99);
            if (sent >= 300 && !pressed) begin
                // fill the chain while the receiver holds off
                pressed = 1'b1;
                hold_asked++;
                set_len = CAP + 3;
            end else if (pick < 60) begin
                set_len = $urandom_range(6, 1);
            end else if (pick < 80) begin
                set_len = $urandom_range(20, 7);
            end else if (pick < 88) begin
                set_len = $urandom_range(CAP - 1, 21);
            end else if (pick < 93) begin
                set_len = CAP;
            end else if (pick < 96) begin
                set_len = CAP + 1;
            end else begin
                set_len = $urandom_range(CAP + 8, CAP + 2);
            end
            for (k = 0; k < set_len; k++) begin
                case ($urandom_range(3))
                    0: v = $signed($urandom_range(8)) - 4;
                    1: begin
                        case ($urandom_range(3))
                            0: v = INT_MIN;
                            1: v = INT_MAX;
                            2: v = 0;
                            default: v = -1;
                        endcase
                    end
                    default: v = $urandom;
                endcase
                r.value        = v;
                r.last_element = (k == set_len - 1);
                send_request(r, 1'b0, no_want);
                sent++;
            end
        end
        tx_valid <= 1'b0;

        // Drain the outstanding results, then let the block settle
        while (sorted_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sorted_due.size() != 0) begin
            fail_count++;
            $display("%0d sorted results never arrived", sorted_due.size());
        end
        if (fail_count == 0) begin
            $display("PASS ascending_integer_sorter");
        end else begin
            $display("FAIL ascending_integer_sorter");
        end
        $finish;
    end

endmodule
